### sv/jmwp_pkg.sv
// Package for the JPEG marker word packer.
// Holds the FIFO size, marker codes and the step result type.
// No dependencies.
`timescale 1ns / 1ps

package jmwp_pkg;

  // FIFO depth in bytes, sets the pad word count at the end marker.
  localparam int FIFO_BYTES = 4096;

  localparam logic [16:0] FIFO_BYTES_X   = 17'(FIFO_BYTES);
  localparam logic [16:0] FIFO_BYTES_X1  = 17'(FIFO_BYTES + 1);

  // Marker bytes and the fixed words they produce.
  localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
  localparam logic [7:0]  MARKER_SOI    = 8'hD8;
  localparam logic [7:0]  MARKER_EOI    = 8'hD9;
  localparam logic [15:0] WORD_SOI      = 16'hFFD8;
  localparam logic [15:0] WORD_EOI_PAD  = 16'hD900;

  // Result of one byte step.
  typedef struct packed {
    logic        emit;
    logic [15:0] fifo_word;
    logic        frame_end;
    logic [11:0] pad_words;
  } step_res_t;

endpackage

### sv/jmwp_if.sv
// Valid/ready channel interfaces for the JPEG marker word packer.
// Depends on nothing; widths follow the byte and word formats.
`timescale 1ns / 1ps

interface jmwp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface jmwp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] fifo_word;
  logic        frame_end;
  logic [11:0] pad_words;

  modport source (output valid, output fifo_word, output frame_end, output pad_words,
                  input ready);
  modport sink   (input valid, input fifo_word, input frame_end, input pad_words,
                  output ready);
endinterface

### sv/jpeg_marker_word_packer_top.sv
// An accepted byte is held in the input register, then its word passes through the output register to out_ch.
// Throughput: one byte per cycle; the input register takes a byte while a word waits.
// Stalls propagate back from out_ch.ready through the output register to in_ch.ready.
// Reset (synchronous, rst_n low): both stages empty, out of frame, no prefix seen, count at 1.
// Depends on jmwp_pkg, jmwp_if and jmwp_step.
`timescale 1ns / 1ps

module jpeg_marker_word_packer_top (
  input  logic        clk,
  input  logic        rst_n,
  jmwp_in_if.sink     in_ch,
  jmwp_out_if.source  out_ch
);

  logic                in_valid_r;
  logic [7:0]          in_byte_r;
  logic                out_valid_r;
  logic [15:0]         out_word_r;
  logic                out_end_r;
  logic [11:0]         out_pad_r;
  logic                out_free;
  logic                advance;
  jmwp_pkg::step_res_t res;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || advance;

  // Packing and framing for the byte in the input register.
  jmwp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // Output register; a byte without a word leaves it empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res.emit;
    end
    if (advance && res.emit) begin
      out_word_r <= res.fifo_word;
      out_end_r  <= res.frame_end;
      out_pad_r  <= res.pad_words;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.fifo_word = out_word_r;
  assign out_ch.frame_end = out_end_r;
  assign out_ch.pad_words = out_pad_r;

`ifndef ASSERT_OFF
  // Pad words appear only on the closing word.
  a_pad_only_at_end : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_end_r) |-> (out_pad_r == 12'd0))
    else $error("pad count on a word that does not close the frame");

  // A closing word either ends in the end marker byte or is the padded marker word.
  a_end_word_form : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |->
      ((out_word_r[7:0] == jmwp_pkg::MARKER_EOI) || (out_word_r == jmwp_pkg::WORD_EOI_PAD)))
    else $error("closing word has an unexpected form");

  // A byte held back by a stalled output keeps its value.
  a_in_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_free) |=> (in_valid_r && $stable(in_byte_r)))
    else $error("stalled input byte was lost or changed");
`endif

endmodule

### sv/jmwp_step.sv
// Per-byte framing state and word packing logic.
// Depends on jmwp_pkg for marker codes, FIFO size and the result struct.
`timescale 1ns / 1ps

module jmwp_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  output jmwp_pkg::step_res_t res
);

  logic        in_frame_r, in_frame_nxt;
  logic        prefix_r, prefix_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  hold_r, hold_nxt;

  logic [15:0] cnt_inc;
  logic [15:0] cnt_end;
  logic        odd;
  logic        is_soi;
  logic        is_eoi;
  logic [16:0] diff;

  // Count advance, marker detection and word assembly.
  always_comb begin
    cnt_inc      = count_r + 16'd1;
    odd          = cnt_inc[0];
    is_soi       = prefix_r && (rx_byte == jmwp_pkg::MARKER_SOI);
    is_eoi       = prefix_r && (rx_byte == jmwp_pkg::MARKER_EOI);
    cnt_end      = odd ? cnt_inc : (cnt_inc + 16'd1);

    hold_nxt     = odd ? hold_r : rx_byte;
    prefix_nxt   = (rx_byte == jmwp_pkg::MARKER_PREFIX);
    in_frame_nxt = in_frame_r;
    count_nxt    = cnt_inc;

    res.emit      = odd && in_frame_r;
    res.fifo_word = {hold_r, rx_byte};
    res.frame_end = 1'b0;
    res.pad_words = 12'd0;

    // Pad count: (FIFO_BYTES - count) / 2 truncated toward zero, plus one.
    // It is zero once that quotient goes negative.
    diff = jmwp_pkg::FIFO_BYTES_X - {1'b0, cnt_end};

    if (is_soi) begin
      in_frame_nxt  = 1'b1;
      count_nxt     = 16'd1;
      res.fifo_word = jmwp_pkg::WORD_SOI;
      res.emit      = 1'b1;
    end else if (is_eoi) begin
      in_frame_nxt  = 1'b0;
      count_nxt     = 16'd1;
      if (!odd) begin
        res.fifo_word = jmwp_pkg::WORD_EOI_PAD;
      end
      res.emit      = 1'b1;
      res.frame_end = 1'b1;
      if ({1'b0, cnt_end} <= jmwp_pkg::FIFO_BYTES_X) begin
        res.pad_words = diff[12:1] + 12'd1;
      end else if ({1'b0, cnt_end} == jmwp_pkg::FIFO_BYTES_X1) begin
        res.pad_words = 12'd1;
      end
    end
  end

  // Framing state, updated once per accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      prefix_r   <= 1'b0;
      count_r    <= 16'd1;
      hold_r     <= 8'd0;
    end else if (fire) begin
      in_frame_r <= in_frame_nxt;
      prefix_r   <= prefix_nxt;
      count_r    <= count_nxt;
      hold_r     <= hold_nxt;
    end
  end

endmodule

### test/tb_jpeg_marker_word_packer_top.sv
// Testbench for jpeg_marker_word_packer_top: byte stream in, framed FIFO words out.
// Depends on jmwp_pkg, the jmwp_in_if / jmwp_out_if interfaces and the top level.
// A built-in word predictor is compared field by field against every accepted result.
`timescale 1ns / 1ps

module tb_jpeg_marker_word_packer_top;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 400;

  // One expected FIFO word with its framing fields.
  typedef struct packed {
    logic [15:0] word;
    logic        frame_end;
    logic [11:0] pad;
  } fifo_word_t;

  logic clk = 1'b0;
  logic rst_n;

  jmwp_in_if  in_ch ();
  jmwp_out_if out_ch ();

  jpeg_marker_word_packer_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // Predictor state of the packer.
  logic        pk_in_frame = 1'b0;
  logic        pk_prefix   = 1'b0;
  logic [15:0] pk_count    = 16'd1;
  logic [7:0]  pk_hold     = 8'd0;

  fifo_word_t pending_words[$];
  int errors      = 0;
  int bytes_sent  = 0;
  int cycle_cnt   = 0;

  // Idling knobs: src_idle_pct for the sender task, snk_stall_pct and hold_ticket for the receiver process.
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_ticket   = 0;

  // Work out the word (if any) that one accepted byte causes.
  task automatic predict_byte(input logic [7:0] b);
    logic [15:0] w;
    logic        emit;
    logic        fend;
    logic [11:0] pad;
    int          diff;
    int          q;
    w    = 16'd0;
    emit = 1'b0;
    fend = 1'b0;
    pad  = 12'd0;
    pk_count = pk_count + 16'd1;
    if (pk_count[0]) begin
      w    = {pk_hold, b};
      emit = pk_in_frame;
    end else begin
      pk_hold = b;
    end
    if (b == jmwp_pkg::MARKER_PREFIX) begin
      pk_prefix = 1'b1;
    end else begin
      if (pk_prefix) begin
        if (b == jmwp_pkg::MARKER_SOI) begin
          pk_in_frame = 1'b1;
          pk_count    = 16'd1;
          w           = jmwp_pkg::WORD_SOI;
          emit        = 1'b1;
        end else if (b == jmwp_pkg::MARKER_EOI) begin
          pk_in_frame = 1'b0;
          // The end marker landing on a high byte closes the word with padding.
          if (!pk_count[0]) begin
            w        = jmwp_pkg::WORD_EOI_PAD;
            pk_count = pk_count + 16'd1;
          end
          emit = 1'b1;
          fend = 1'b1;
        end
      end
      pk_prefix = 1'b0;
    end
    if (fend) begin
      // Integer division truncates toward zero; negative quotients give no padding.
      diff = jmwp_pkg::FIFO_BYTES - int'(pk_count);
      q    = diff / 2;
      pad  = (q < 0) ? 12'd0 : 12'(q + 1);
      pk_count = 16'd1;
    end
    if (emit) pending_words.push_back('{w, fend, pad});
  endtask

  // Offer one byte, with random idle cycles first, and predict it once accepted.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Random payload byte that never forms a start or end marker with its predecessor.
  function automatic logic [7:0] payload_byte(input logic [7:0] prev);
    logic [7:0] b;
    b = ($urandom_range(9) == 0) ? jmwp_pkg::MARKER_PREFIX : 8'($urandom);
    if (prev == jmwp_pkg::MARKER_PREFIX &&
        (b == jmwp_pkg::MARKER_SOI || b == jmwp_pkg::MARKER_EOI)) begin
      b = 8'($urandom_range(127));
    end
    return b;
  endfunction

  // A well-formed image: start marker, payload, end marker.
  task automatic send_frame(input int n);
    logic [7:0] prev;
    prev = 8'h00;
    send_byte(jmwp_pkg::MARKER_PREFIX);
    send_byte(jmwp_pkg::MARKER_SOI);
    for (int i = 0; i < n; i++) begin
      prev = payload_byte(prev);
      send_byte(prev);
    end
    send_byte(jmwp_pkg::MARKER_PREFIX);
    send_byte(jmwp_pkg::MARKER_EOI);
  endtask

  // Receiver: random stalls, plus a long hold-off each time the ticket moves.
  always @(negedge clk) begin
    static int hold_seen = 0;
    static int hold_left = 0;
    if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    fifo_word_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("fifo_word: expected none, got %h", out_ch.fifo_word);
        errors++;
      end else begin
        exp_w = pending_words.pop_front();
        if (out_ch.fifo_word !== exp_w.word) begin
          $error("fifo_word: expected %h, got %h", exp_w.word, out_ch.fifo_word);
          errors++;
        end
        if (out_ch.frame_end !== exp_w.frame_end) begin
          $error("frame_end: expected %b, got %b", exp_w.frame_end, out_ch.frame_end);
          errors++;
        end
        if (out_ch.pad_words !== exp_w.pad) begin
          $error("pad_words: expected %0d, got %0d", exp_w.pad, out_ch.pad_words);
          errors++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Marker corner cases with hand-picked bytes.
  task automatic test_directed();
    logic [7:0] seq[] = '{
      8'h00, 8'hFF, 8'hD9,                      // end marker with no open frame
      8'hD8,                                    // start byte without a prefix
      8'hFF, 8'hD8,                             // open a frame
      8'h12, 8'h80, 8'h7F, 8'hFF,               // plain words, extreme bytes
      8'hFF, 8'hFF, 8'h00,                      // repeated prefix, then cleared
      8'hAB, 8'hFF, 8'hD8,                      // start while the D8 completes a word
      8'hAB, 8'hFF, 8'hD9,                      // end falling on a high byte
      8'hFF, 8'hD8, 8'hFF, 8'hD9,               // end completing a word
      8'hD9                                     // end byte without a prefix
    };
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken sequences.
  task automatic run_random_phase(input int n_items, input int src_pct, input int snk_pct);
    int stop_at;
    int kind;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        send_frame($urandom_range(30));
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end else begin
        case ($urandom_range(2))
          0: begin
            // Start with no end.
            send_byte(jmwp_pkg::MARKER_PREFIX);
            send_byte(jmwp_pkg::MARKER_SOI);
            repeat ($urandom_range(6)) send_byte(8'($urandom_range(127)));
          end
          1: begin
            // Bare end, with extra prefix bytes.
            repeat ($urandom_range(1, 3)) send_byte(jmwp_pkg::MARKER_PREFIX);
            send_byte(jmwp_pkg::MARKER_EOI);
          end
          default: begin
            send_byte(8'($urandom_range(127)));
            send_byte(jmwp_pkg::MARKER_EOI);
            send_byte(jmwp_pkg::MARKER_SOI);
          end
        endcase
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(225, 0, 0);
    run_random_phase(225, 75, 0);
    run_random_phase(225, 0, 75);
    run_random_phase(225, 31, 31);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
  endtask

  // Long receiver hold-off while the sender keeps offering a frame.
  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_ticket++;
    send_frame(60);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_traffic();
    test_backpressure();

    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
